### rtl/hsv2rgb_pkg.sv
// hsv2rgb_pkg: shared types and fixed-point constants for the hsv to rgb converter
// no dependencies; imported by every module of the converter
`default_nettype none

package hsv2rgb_pkg;

  // field widths
  localparam int unsigned HUE_W    = 15;
  localparam int unsigned PCT_W    = 13;
  localparam int unsigned OUT_W    = 12;
  localparam int unsigned REM_W    = 12;
  localparam int unsigned V4080_W  = 25;
  localparam int unsigned FACTOR_W = 25;
  localparam int unsigned PROD_W   = 50;
  localparam int unsigned QUO_W    = 26;
  localparam int unsigned RECIP_W  = 27;
  localparam int unsigned MK_W     = QUO_W + RECIP_W;
  localparam int unsigned LVL_W    = 13;

  // scale constants
  localparam logic [PCT_W-1:0]    PCT_FULL     = 13'd6400;
  localparam logic [REM_W-1:0]    SECTOR_UNITS = 12'd3840;
  localparam logic [OUT_W-1:0]    OUT_FULL     = 12'd4080;
  localparam logic [FACTOR_W-1:0] FULL_FACTOR  = 25'd24576000;

  // full denominator 6400*6400*3840 = 2^24 * 9375, rounded by adding half of it
  localparam logic [PROD_W-1:0] HALF_DEN    = 50'd78643200000;
  localparam int unsigned       DEN_SHIFT   = 24;
  localparam int unsigned       DEN_ODD     = 9375;
  localparam int unsigned       RECIP_SHIFT = 40;
  // ceiling reciprocal of the odd part; exact for every quotient input below 2^26
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_pixel_t;

  // after the hue split
  typedef struct packed {
    sector_t              sector;
    logic [REM_W-1:0]     rem;
    logic [PCT_W-1:0]     sat;
    logic [V4080_W-1:0]   val4080;
  } split_t;

  // after the saturation factors
  typedef struct packed {
    sector_t               sector;
    logic [V4080_W-1:0]    val4080;
    logic [FACTOR_W-1:0]   fp;
    logic [FACTOR_W-1:0]   fq;
    logic [FACTOR_W-1:0]   ft;
  } factor_t;

endpackage

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: top level, six-stage pipeline from hsv pixel to rgb pixel
// depends on hsv2rgb_pkg, hsv2rgb_split, hsv2rgb_factor, hsv2rgb_scale
`default_nettype none

// Converts one HSV pixel per clock. A beat is taken on every cycle with start high;
// busy is always low since the pipeline never stalls. The result appears on
// out_pixel with out_valid high for one cycle, after the pipeline stages
// (clamp and hue split, saturation factors, brightness product, denominator
// reduction, reciprocal multiply, sector routing). Throughput is one pixel per clock
// and results leave in the order the beats came in; the receiver cannot hold them.
// Saturation and brightness above 100 percent are clamped, hue wraps every 360 degrees.

module hsv_to_rgb_converter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  hsv2rgb_pkg::hsv_pixel_t in_pixel,
  output logic                    out_valid,
  output hsv2rgb_pkg::rgb_pixel_t out_pixel
);
  import hsv2rgb_pkg::*;

  logic        s1_valid;
  split_t      s1_data;
  logic        s2_valid;
  factor_t     s2_data;
  logic [2:0]  vld_r;
  sector_t     sec_r [3];
  logic [OUT_W-1:0] lv_v;
  logic [OUT_W-1:0] lv_p;
  logic [OUT_W-1:0] lv_q;
  logic [OUT_W-1:0] lv_t;
  rgb_pixel_t  pix_nxt;
  rgb_pixel_t  pix_r;
  logic        out_valid_r;

  assign busy = 1'b0;

  // stage 1
  hsv2rgb_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_pixel  (in_pixel),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  // stage 2
  hsv2rgb_factor u_factor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  // stages 3 to 5, one unit per term
  hsv2rgb_scale u_scale_v (
    .clk (clk), .val4080 (s2_data.val4080), .factor (FULL_FACTOR), .level (lv_v)
  );
  hsv2rgb_scale u_scale_p (
    .clk (clk), .val4080 (s2_data.val4080), .factor (s2_data.fp), .level (lv_p)
  );
  hsv2rgb_scale u_scale_q (
    .clk (clk), .val4080 (s2_data.val4080), .factor (s2_data.fq), .level (lv_q)
  );
  hsv2rgb_scale u_scale_t (
    .clk (clk), .val4080 (s2_data.val4080), .factor (s2_data.ft), .level (lv_t)
  );

  // valid bits alongside the scale units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 3'b000;
    end else begin
      vld_r <= {vld_r[1:0], s2_valid};
    end
  end

  // sector alongside the scale units
  always_ff @(posedge clk) begin
    sec_r[0] <= s2_data.sector;
    sec_r[1] <= sec_r[0];
    sec_r[2] <= sec_r[1];
  end

  // route terms by sector
  always_comb begin
    unique case (sec_r[2])
      SECT_RED_YEL: pix_nxt = '{red: lv_v, green: lv_t, blue: lv_p};
      SECT_YEL_GRN: pix_nxt = '{red: lv_q, green: lv_v, blue: lv_p};
      SECT_GRN_CYN: pix_nxt = '{red: lv_p, green: lv_v, blue: lv_t};
      SECT_CYN_BLU: pix_nxt = '{red: lv_p, green: lv_q, blue: lv_v};
      SECT_BLU_MAG: pix_nxt = '{red: lv_t, green: lv_p, blue: lv_v};
      default:      pix_nxt = '{red: lv_v, green: lv_p, blue: lv_q};
    endcase
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[2];
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pix_r;

`ifndef NO_ASSERTIONS
  // every accepted beat comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##6 out_valid)
    else $error("accepted beat did not produce a result");

  // no result without an earlier accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without an accepted beat");

  // zero brightness gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_pixel.brightness == '0) |-> ##6
      (out_pixel.red == '0 && out_pixel.green == '0 && out_pixel.blue == '0))
    else $error("zero brightness did not give black");

  // zero saturation gives gray
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_pixel.saturation == '0) |-> ##6
      (out_pixel.red == out_pixel.green && out_pixel.green == out_pixel.blue))
    else $error("zero saturation did not give gray");
`endif

endmodule

`default_nettype wire

### rtl/hsv2rgb_split.sv
// hsv2rgb_split: first pipeline stage, clamps inputs and splits hue into sector and remainder
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_split (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  hsv2rgb_pkg::hsv_pixel_t in_pixel,
  output logic                    out_valid,
  output hsv2rgb_pkg::split_t     out_data
);
  import hsv2rgb_pkg::*;

  localparam int MAX_TURNS = (1 << HUE_W) / SECTOR_UNITS;

  logic [PCT_W-1:0]   sat_c;
  logic [PCT_W-1:0]   val_c;
  logic [3:0]         turn_c;
  logic [HUE_W-1:0]   base_c;
  logic [2:0]         sect_c;
  split_t             data_nxt;
  split_t             data_r;
  logic               valid_r;

  // clamp, count whole sectors, take remainder
  always_comb begin
    sat_c = (in_pixel.saturation > PCT_FULL) ? PCT_FULL : in_pixel.saturation;
    val_c = (in_pixel.brightness > PCT_FULL) ? PCT_FULL : in_pixel.brightness;
    turn_c = 4'd0;
    for (int k = 1; k <= MAX_TURNS; k++) begin
      if (in_pixel.hue >= HUE_W'(k * SECTOR_UNITS)) begin
        turn_c = turn_c + 4'd1;
      end
    end
    base_c = HUE_W'(turn_c) * HUE_W'(SECTOR_UNITS);
    sect_c = (turn_c >= 4'd6) ? 3'(turn_c - 4'd6) : turn_c[2:0];
    data_nxt.sector  = sector_t'(sect_c);
    data_nxt.rem     = REM_W'(in_pixel.hue - base_c);
    data_nxt.sat     = sat_c;
    data_nxt.val4080 = V4080_W'(val_c) * V4080_W'(OUT_FULL);
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/hsv2rgb_factor.sv
// hsv2rgb_factor: second pipeline stage, forms the p, q and t saturation factors
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_factor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  hsv2rgb_pkg::split_t  in_data,
  output logic                 out_valid,
  output hsv2rgb_pkg::factor_t out_data
);
  import hsv2rgb_pkg::*;

  logic [FACTOR_W-1:0] sat_c;
  logic [REM_W-1:0]    comp_c;
  factor_t             data_nxt;
  factor_t             data_r;
  logic                valid_r;

  // factors in units of 1/(6400*3840)
  always_comb begin
    sat_c  = FACTOR_W'(in_data.sat);
    comp_c = SECTOR_UNITS - in_data.rem;
    data_nxt.sector  = in_data.sector;
    data_nxt.val4080 = in_data.val4080;
    data_nxt.fp      = FULL_FACTOR - sat_c * FACTOR_W'(SECTOR_UNITS);
    data_nxt.fq      = FULL_FACTOR - sat_c * FACTOR_W'(in_data.rem);
    data_nxt.ft      = FULL_FACTOR - sat_c * FACTOR_W'(comp_c);
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/hsv2rgb_scale.sv
// hsv2rgb_scale: three register stages that scale one factor by brightness and divide
// by the full denominator with round to nearest; depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_scale (
  input  logic                                clk,
  input  logic [hsv2rgb_pkg::V4080_W-1:0]     val4080,
  input  logic [hsv2rgb_pkg::FACTOR_W-1:0]    factor,
  output logic [hsv2rgb_pkg::OUT_W-1:0]       level
);
  import hsv2rgb_pkg::*;

  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] sum_c;
  logic [QUO_W-1:0]  quo_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [MK_W-1:0]   mk_nxt;
  logic [MK_W-1:0]   mk_r;
  logic [LVL_W-1:0]  lvl_c;

  // numerator, drop the power-of-two part of the denominator, reciprocal multiply
  always_comb begin
    prod_nxt = PROD_W'(val4080) * PROD_W'(factor);
    sum_c    = prod_r + HALF_DEN;
    quo_nxt  = sum_c[DEN_SHIFT +: QUO_W];
    mk_nxt   = MK_W'(quo_r) * MK_W'(RECIP_K);
    lvl_c    = mk_r[RECIP_SHIFT +: LVL_W];
    level    = (lvl_c > LVL_W'(OUT_FULL)) ? OUT_FULL : lvl_c[OUT_W-1:0];
  end

  // payload stages
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    mk_r   <= mk_nxt;
  end

endmodule

`default_nettype wire
